/* src/pidf_pkg.sv */
// types, constants and saturation helpers for the multi-channel pid regulator
package pidf_pkg;

  // field and register widths
  localparam int CHAN_W    = 2;
  localparam int VAL_W     = 24;
  localparam int DRIVE_W   = 32;
  localparam int GAIN_W    = 24;
  localparam int BETA_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  // internal datapath widths
  localparam int ERR_W   = 25;
  localparam int DIFF_W  = 26;
  localparam int STATE_W = 40;
  localparam int SPLIT_W = 20;
  localparam int MX_W    = 33;
  localparam int MY_W    = 25;
  localparam int PROD_W  = MX_W + MY_W;
  localparam int ACC_W   = 66;
  localparam int OSUM_W  = 50;

  // operation codes
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_SETPOINT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 2'd3;

  // fixed coefficients
  localparam logic signed [MY_W-1:0] STEP_002    = 25'sd1311;
  localparam logic signed [MY_W-1:0] DERIV_SCALE = 25'sd50;
  localparam logic [BETA_W-1:0]      BETA_ONE    = 17'd65536;
  localparam logic [BETA_W-1:0]      BETA_RESET  = 17'd45875;

  // accumulator operations
  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_FIRST = 2'd1;
  localparam logic [1:0] ACC_ADD   = 2'd2;

  // rounding shifts
  localparam logic [1:0] RND_NONE = 2'd0;
  localparam logic [1:0] RND_8    = 2'd1;
  localparam logic [1:0] RND_16   = 2'd2;
  localparam logic [1:0] RND_24   = 2'd3;

  typedef struct packed {
    logic                     operation;
    logic [CHAN_W-1:0]        channel;
    logic signed [VAL_W-1:0]  value;
  } pidf_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]         out_channel;
    logic signed [DRIVE_W-1:0] drive;
  } pidf_out_t;

  // controls for the shared multiply-accumulate unit
  typedef struct packed {
    logic       mul_en;
    logic [1:0] acc_op;
    logic       acc_sh;
    logic [1:0] rnd_op;
  } mac_ctrl_t;

  // clamp to the signed state range
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] max_v;
    logic signed [ACC_W:0] min_v;
    max_v = {{(ACC_W-STATE_W+2){1'b0}}, {(STATE_W-1){1'b1}}};
    min_v = {{(ACC_W-STATE_W+2){1'b1}}, {(STATE_W-1){1'b0}}};
    if (v > max_v) begin
      sat_state = max_v[STATE_W-1:0];
    end else if (v < min_v) begin
      sat_state = min_v[STATE_W-1:0];
    end else begin
      sat_state = v[STATE_W-1:0];
    end
  endfunction

  // clamp to the signed drive range
  function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [OSUM_W-1:0] v);
    logic signed [OSUM_W-1:0] max_v;
    logic signed [OSUM_W-1:0] min_v;
    max_v = {{(OSUM_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
    min_v = {{(OSUM_W-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};
    if (v > max_v) begin
      sat_drive = max_v[DRIVE_W-1:0];
    end else if (v < min_v) begin
      sat_drive = min_v[DRIVE_W-1:0];
    end else begin
      sat_drive = v[DRIVE_W-1:0];
    end
  endfunction

endpackage

/* src/pidf_mac.sv */
// shared multiplier, shifting accumulator and round-half-away rounder
module pidf_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pidf_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [pidf_pkg::MX_W-1:0]     x_i,
  input  logic signed [pidf_pkg::MY_W-1:0]     y_i,
  output logic signed [pidf_pkg::PROD_W-1:0]   prod_o,
  output logic signed [pidf_pkg::ACC_W-1:0]    rnd_o
);

  localparam logic signed [pidf_pkg::ACC_W-1:0] HALF_8  = pidf_pkg::ACC_W'(128);
  localparam logic signed [pidf_pkg::ACC_W-1:0] HALF_16 = pidf_pkg::ACC_W'(32768);
  localparam logic signed [pidf_pkg::ACC_W-1:0] HALF_24 = pidf_pkg::ACC_W'(8388608);

  logic signed [pidf_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [pidf_pkg::ACC_W-1:0]  acc_d, acc_q;
  logic signed [pidf_pkg::ACC_W-1:0]  rnd_d, rnd_q;
  logic signed [pidf_pkg::ACC_W-1:0]  addend;
  logic signed [pidf_pkg::ACC_W-1:0]  neg_s;
  logic signed [pidf_pkg::ACC_W-1:0]  biased;
  logic                               rst_seen_q;

  // one multiply per cycle, registered while mul_en is set
  assign prod_d = pidf_pkg::PROD_W'(x_i) * pidf_pkg::PROD_W'(y_i);

  // upper partial products land one split width higher
  always_comb begin
    if (ctrl_i.acc_sh) begin
      addend = pidf_pkg::ACC_W'(prod_q) <<< pidf_pkg::SPLIT_W;
    end else begin
      addend = pidf_pkg::ACC_W'(prod_q);
    end
  end

  always_comb begin
    case (ctrl_i.acc_op)
      pidf_pkg::ACC_FIRST: acc_d = addend;
      pidf_pkg::ACC_ADD:   acc_d = acc_q + addend;
      default:             acc_d = acc_q;
    endcase
  end

  // round to nearest, halves away from zero
  assign neg_s = pidf_pkg::ACC_W'(acc_q[pidf_pkg::ACC_W-1]);

  always_comb begin
    case (ctrl_i.rnd_op)
      pidf_pkg::RND_8: begin
        biased = acc_q + HALF_8 - neg_s;
        rnd_d  = biased >>> 8;
      end
      pidf_pkg::RND_16: begin
        biased = acc_q + HALF_16 - neg_s;
        rnd_d  = biased >>> 16;
      end
      pidf_pkg::RND_24: begin
        biased = acc_q + HALF_24 - neg_s;
        rnd_d  = biased >>> 24;
      end
      default: begin
        biased = acc_q;
        rnd_d  = rnd_q;
      end
    endcase
  end

  // marks the unit out of reset; gates the datapath enables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_seen_q <= 1'b0;
    end else begin
      rst_seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rst_seen_q && ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (rst_seen_q) begin
      acc_q <= acc_d;
      rnd_q <= rnd_d;
    end
  end

  assign prod_o = prod_q;
  assign rnd_o  = rnd_q;

endmodule

/* src/multi_channel_pid_filtered_derivative.sv */
// multi-channel pid speed regulator with a low-pass filtered derivative
//
// Input channel (in_valid_i / in_stall_o / in_data_i): each transfer names a channel.
// A setpoint item stores the target, clears that channel's last error and integral,
// leaves the block idle and gives no result. A sample item is worked through one shared
// multiply-accumulate unit under a step counter: thirteen steps of arithmetic
// (ten multiplies plus rounding and saturation), then the result is loaded into the
// output register. The input stalls from the transfer of a sample until its result
// is loaded, so the next item is taken only after that; samples do not overlap, as
// they share the single multiplier. Items on a channel at or above CHANNELS are taken
// and dropped.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per sample.
// While the receiver stalls the result holds and the next item may still be taken
// and computed; the block then waits at its last step until the register frees.
// Configuration (cfg_we_i / cfg_idx_i / cfg_wdata_i): gains and derivative smoothing,
// written while the block is idle.
// Reset clears every channel's state, the gains, and sets the smoothing weight to 0.7.
module multi_channel_pid_filtered_derivative #(
  parameter int CHANNELS = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pidf_pkg::pidf_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pidf_pkg::pidf_out_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [pidf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pidf_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // step codes; each multiply step is named after the multiply issued in it
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL_INT   = 4'd1;
  localparam logic [3:0] S_MUL_SLOPE = 4'd2;
  localparam logic [3:0] S_MUL_DHI   = 4'd3;
  localparam logic [3:0] S_MUL_DLO   = 4'd4;
  localparam logic [3:0] S_MUL_RAW   = 4'd5;
  localparam logic [3:0] S_MUL_KP    = 4'd6;
  localparam logic [3:0] S_MUL_KIHI  = 4'd7;
  localparam logic [3:0] S_MUL_KILO  = 4'd8;
  localparam logic [3:0] S_MUL_KDHI  = 4'd9;
  localparam logic [3:0] S_MUL_KDLO  = 4'd10;
  localparam logic [3:0] S_SUM_KI    = 4'd11;
  localparam logic [3:0] S_RND_KD    = 4'd12;
  localparam logic [3:0] S_SUM_KD    = 4'd13;
  localparam logic [3:0] S_OUT       = 4'd14;

  logic [3:0] step_d, step_q;

  // configuration registers
  logic [pidf_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [pidf_pkg::BETA_W-1:0] smooth_cfg_q;
  logic [pidf_pkg::BETA_W-1:0] beta_eff, beta_inv;

  // per-channel state
  logic signed [pidf_pkg::VAL_W-1:0]   target_q   [CHANNELS];
  logic signed [pidf_pkg::ERR_W-1:0]   last_err_q [CHANNELS];
  logic signed [pidf_pkg::STATE_W-1:0] err_sum_q  [CHANNELS];
  logic signed [pidf_pkg::STATE_W-1:0] smooth_q   [CHANNELS];

  // per-item working registers
  logic [pidf_pkg::CHAN_W-1:0]         ch_q;
  logic signed [pidf_pkg::VAL_W-1:0]   val_q;
  logic signed [pidf_pkg::ERR_W-1:0]   err_q;
  logic signed [pidf_pkg::DIFF_W-1:0]  diff_q;
  logic signed [pidf_pkg::MX_W-1:0]    raw_q;
  logic signed [pidf_pkg::STATE_W-1:0] isum_q;
  logic signed [pidf_pkg::STATE_W-1:0] filt_q;
  logic signed [pidf_pkg::OSUM_W-1:0]  osum_q;

  logic                out_valid_q;
  pidf_pkg::pidf_out_t out_data_q;

  logic [CH_IW-1:0] in_idx, idx;
  logic             in_fire, ch_ok, out_load, out_free;
  logic signed [pidf_pkg::STATE_W-1:0] d_cur;

  pidf_pkg::mac_ctrl_t                  mac_ctrl;
  logic signed [pidf_pkg::MX_W-1:0]     mac_x;
  logic signed [pidf_pkg::MY_W-1:0]     mac_y;
  logic signed [pidf_pkg::PROD_W-1:0]   prod;
  logic signed [pidf_pkg::ACC_W-1:0]    rnd;

  // handshake
  assign in_stall_o = (step_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign ch_ok      = (32'(in_data_i.channel) < CHANNELS);
  assign in_idx     = CH_IW'(in_data_i.channel);
  assign idx        = CH_IW'(ch_q);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (step_q == S_OUT) && out_free;

  // a smoothing weight above one acts as one
  assign beta_eff = smooth_cfg_q[pidf_pkg::BETA_W-1] ? pidf_pkg::BETA_ONE : smooth_cfg_q;
  assign beta_inv = pidf_pkg::BETA_ONE - beta_eff;
  assign d_cur    = smooth_q[idx];

  // step sequencing
  always_comb begin
    step_d = step_q;
    case (step_q)
      S_IDLE: begin
        if (in_fire && ch_ok && (in_data_i.operation == pidf_pkg::OP_SAMPLE)) begin
          step_d = S_MUL_INT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          step_d = S_IDLE;
        end
      end
      default: step_d = step_q + 4'd1;
    endcase
  end

  // operand selection and unit control for each step
  always_comb begin
    mac_x    = '0;
    mac_y    = '0;
    mac_ctrl = '{mul_en: 1'b0, acc_op: pidf_pkg::ACC_NONE, acc_sh: 1'b0,
                 rnd_op: pidf_pkg::RND_NONE};
    case (step_q)
      S_MUL_INT: begin
        mac_x = pidf_pkg::MX_W'(err_q);
        mac_y = pidf_pkg::STEP_002;
        mac_ctrl.mul_en = 1'b1;
      end
      S_MUL_SLOPE: begin
        mac_x = pidf_pkg::MX_W'(diff_q);
        mac_y = pidf_pkg::DERIV_SCALE;
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = pidf_pkg::ACC_FIRST;
      end
      S_MUL_DHI: begin
        mac_x = pidf_pkg::MX_W'(signed'(d_cur[pidf_pkg::STATE_W-1:pidf_pkg::SPLIT_W]));
        mac_y = pidf_pkg::MY_W'(beta_eff);
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.rnd_op = pidf_pkg::RND_8;
      end
      S_MUL_DLO: begin
        mac_x = pidf_pkg::MX_W'(d_cur[pidf_pkg::SPLIT_W-1:0]);
        mac_y = pidf_pkg::MY_W'(beta_eff);
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = pidf_pkg::ACC_FIRST;
        mac_ctrl.acc_sh = 1'b1;
      end
      S_MUL_RAW: begin
        mac_x = raw_q;
        mac_y = pidf_pkg::MY_W'(beta_inv);
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = pidf_pkg::ACC_ADD;
      end
      S_MUL_KP: begin
        mac_x = pidf_pkg::MX_W'(err_q);
        mac_y = pidf_pkg::MY_W'(gain_p_q);
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = pidf_pkg::ACC_ADD;
      end
      S_MUL_KIHI: begin
        mac_x = pidf_pkg::MX_W'(signed'(isum_q[pidf_pkg::STATE_W-1:pidf_pkg::SPLIT_W]));
        mac_y = pidf_pkg::MY_W'(gain_i_q);
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = pidf_pkg::ACC_FIRST;
        mac_ctrl.rnd_op = pidf_pkg::RND_16;
      end
      S_MUL_KILO: begin
        mac_x = pidf_pkg::MX_W'(isum_q[pidf_pkg::SPLIT_W-1:0]);
        mac_y = pidf_pkg::MY_W'(gain_i_q);
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = pidf_pkg::ACC_FIRST;
        mac_ctrl.acc_sh = 1'b1;
        mac_ctrl.rnd_op = pidf_pkg::RND_16;
      end
      S_MUL_KDHI: begin
        mac_x = pidf_pkg::MX_W'(signed'(filt_q[pidf_pkg::STATE_W-1:pidf_pkg::SPLIT_W]));
        mac_y = pidf_pkg::MY_W'(gain_d_q);
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = pidf_pkg::ACC_ADD;
      end
      S_MUL_KDLO: begin
        mac_x = pidf_pkg::MX_W'(filt_q[pidf_pkg::SPLIT_W-1:0]);
        mac_y = pidf_pkg::MY_W'(gain_d_q);
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = pidf_pkg::ACC_FIRST;
        mac_ctrl.acc_sh = 1'b1;
        mac_ctrl.rnd_op = pidf_pkg::RND_24;
      end
      S_SUM_KI: begin
        mac_ctrl.acc_op = pidf_pkg::ACC_ADD;
      end
      S_RND_KD: begin
        mac_ctrl.rnd_op = pidf_pkg::RND_16;
      end
      default: begin
        mac_ctrl.mul_en = 1'b0;
      end
    endcase
  end

  pidf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .x_i    (mac_x),
    .y_i    (mac_y),
    .prod_o (prod),
    .rnd_o  (rnd)
  );

  // control, configuration and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= S_IDLE;
      out_valid_q  <= 1'b0;
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      smooth_cfg_q <= pidf_pkg::BETA_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        target_q[i]   <= '0;
        last_err_q[i] <= '0;
        err_sum_q[i]  <= '0;
        smooth_q[i]   <= '0;
      end
    end else begin
      step_q <= step_d;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          pidf_pkg::CFG_GAIN_P: gain_p_q     <= cfg_wdata_i;
          pidf_pkg::CFG_GAIN_I: gain_i_q     <= cfg_wdata_i;
          pidf_pkg::CFG_GAIN_D: gain_d_q     <= cfg_wdata_i;
          pidf_pkg::CFG_SMOOTH: smooth_cfg_q <= cfg_wdata_i[pidf_pkg::BETA_W-1:0];
          default: ;
        endcase
      end

      // setpoint load clears the history, keeps the filtered derivative
      if (in_fire && ch_ok && (in_data_i.operation == pidf_pkg::OP_SETPOINT)) begin
        target_q[in_idx]   <= in_data_i.value;
        last_err_q[in_idx] <= '0;
        err_sum_q[in_idx]  <= '0;
      end

      // write back at the end of a sample
      if (out_load) begin
        last_err_q[idx] <= err_q;
        err_sum_q[idx]  <= isum_q;
        smooth_q[idx]   <= filt_q;
      end
    end
  end

  // per-item datapath registers
  always_ff @(posedge clk_i) begin
    if (step_q == S_IDLE && in_fire) begin
      ch_q  <= in_data_i.channel;
      val_q <= in_data_i.value;
      err_q <= pidf_pkg::ERR_W'(target_q[in_idx]) - pidf_pkg::ERR_W'(in_data_i.value);
    end
    case (step_q)
      S_MUL_INT: diff_q <= pidf_pkg::DIFF_W'(err_q) - pidf_pkg::DIFF_W'(last_err_q[idx]);
      S_MUL_DHI: raw_q  <= prod[pidf_pkg::MX_W-1:0];
      S_MUL_DLO: isum_q <= pidf_pkg::sat_state((pidf_pkg::ACC_W+1)'(err_sum_q[idx])
                                               + (pidf_pkg::ACC_W+1)'(rnd));
      S_MUL_KILO: filt_q <= pidf_pkg::sat_state((pidf_pkg::ACC_W+1)'(rnd));
      S_MUL_KDHI: osum_q <= pidf_pkg::OSUM_W'(val_q) + pidf_pkg::OSUM_W'(rnd);
      S_SUM_KI:   osum_q <= osum_q + pidf_pkg::OSUM_W'(rnd);
      S_SUM_KD:   osum_q <= osum_q + pidf_pkg::OSUM_W'(rnd);
      default: ;
    endcase
    if (out_load) begin
      out_data_q.out_channel <= ch_q;
      out_data_q.drive       <= pidf_pkg::sat_drive(osum_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* verif/multi_channel_pid_filtered_derivative_tb.sv */
// self-checking testbench for the multi-channel pid regulator with filtered derivative
`timescale 1ns / 100ps

module multi_channel_pid_filtered_derivative_tb;

  localparam int     CHANNELS      = 3;
  localparam int     TAIL_CYCLES   = 20;
  localparam int     LIMIT_CYCLES  = 400000;
  localparam int     WINDUP_ITEMS  = 40;
  localparam int     RAND_PHASES   = 5;
  localparam int     PHASE_ITEMS   = 110;
  localparam longint SUM_HI        = (longint'(1) <<< (pidf_pkg::STATE_W - 1)) - 1;
  localparam longint SUM_LO        = -(longint'(1) <<< (pidf_pkg::STATE_W - 1));
  localparam longint DRIVE_HI      = (longint'(1) <<< (pidf_pkg::DRIVE_W - 1)) - 1;
  localparam longint DRIVE_LO      = -(longint'(1) <<< (pidf_pkg::DRIVE_W - 1));
  localparam logic signed [pidf_pkg::VAL_W-1:0] VAL_MAX = {1'b0, {(pidf_pkg::VAL_W-1){1'b1}}};
  localparam logic signed [pidf_pkg::VAL_W-1:0] VAL_MIN = {1'b1, {(pidf_pkg::VAL_W-1){1'b0}}};
  localparam logic [pidf_pkg::GAIN_W-1:0]       GAIN_MAX = '1;
  localparam logic [pidf_pkg::GAIN_W-1:0]       GAIN_ONE = 24'h010000;

  // clock, reset and block ports
  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  pidf_pkg::pidf_in_t             in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  pidf_pkg::pidf_out_t            out_data;
  logic                           cfg_we    = 1'b0;
  logic [pidf_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [pidf_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // register mirror and per-channel regulator state
  logic [pidf_pkg::GAIN_W-1:0]         kp;
  logic [pidf_pkg::GAIN_W-1:0]         ki;
  logic [pidf_pkg::GAIN_W-1:0]         kd;
  logic [pidf_pkg::BETA_W-1:0]         beta_reg;
  logic signed [pidf_pkg::VAL_W-1:0]   spd_target  [CHANNELS];
  logic signed [pidf_pkg::ERR_W-1:0]   spd_last_err[CHANNELS];
  logic signed [pidf_pkg::STATE_W-1:0] spd_err_sum [CHANNELS];
  logic signed [pidf_pkg::STATE_W-1:0] spd_slope   [CHANNELS];

  // pending drive values, oldest first
  pidf_pkg::pidf_out_t drive_expect_q[$];
  pidf_pkg::pidf_out_t want;

  // idling control and run tallies
  bit          in_idle_on  = 1'b1;
  bit          out_idle_on = 1'b1;
  int unsigned out_hold    = 0;
  int unsigned mismatches  = 0;
  int unsigned drives_seen = 0;
  int unsigned samples_sent   = 0;
  int unsigned setpoints_sent = 0;
  int unsigned dropped_sent   = 0;
  int unsigned cfg_writes     = 0;
  int unsigned cycle_count    = 0;

  multi_channel_pid_filtered_derivative #(
    .CHANNELS(CHANNELS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // round to nearest, halves away from zero
  function automatic longint round_half_away(input longint v, input int unsigned sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v < 0) begin
      return -((-v + half) >>> sh);
    end
    return (v + half) >>> sh;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // regulator update for one accepted item; returns 1 when a drive value follows
  function automatic bit pid_step(input pidf_pkg::pidf_in_t item,
                                  output pidf_pkg::pidf_out_t res);
    longint      err;
    longint      i_step;
    longint      sum;
    longint      slope;
    longint      beta;
    longint      filt;
    longint      acc;
    longint      fb;
    int unsigned ch;
    res = '0;
    ch  = item.channel;
    if (ch >= CHANNELS) begin
      return 1'b0;
    end
    if (item.operation == pidf_pkg::OP_SETPOINT) begin
      spd_target[ch]   = item.value;
      spd_last_err[ch] = '0;
      spd_err_sum[ch]  = '0;
      return 1'b0;
    end
    fb     = longint'($signed(item.value));
    err    = longint'(spd_target[ch]) - fb;
    i_step = round_half_away(err * longint'(pidf_pkg::STEP_002), 8);
    sum    = clamp_to(longint'(spd_err_sum[ch]) + i_step, SUM_LO, SUM_HI);
    slope  = (err - longint'(spd_last_err[ch])) * longint'(pidf_pkg::DERIV_SCALE);
    beta   = (beta_reg > pidf_pkg::BETA_ONE) ? longint'(pidf_pkg::BETA_ONE)
                                             : longint'(beta_reg);
    filt   = round_half_away(beta * longint'(spd_slope[ch])
                             + (longint'(pidf_pkg::BETA_ONE) - beta) * slope, 16);
    filt   = clamp_to(filt, SUM_LO, SUM_HI);
    acc    = round_half_away(longint'(kp) * err, 16)
           + round_half_away(longint'(ki) * sum, 24)
           + round_half_away(longint'(kd) * filt, 16)
           + fb;
    acc    = clamp_to(acc, DRIVE_LO, DRIVE_HI);
    spd_last_err[ch] = err[pidf_pkg::ERR_W-1:0];
    spd_err_sum[ch]  = sum[pidf_pkg::STATE_W-1:0];
    spd_slope[ch]    = filt[pidf_pkg::STATE_W-1:0];
    res.out_channel  = ch[pidf_pkg::CHAN_W-1:0];
    res.drive        = acc[pidf_pkg::DRIVE_W-1:0];
    return 1'b1;
  endfunction

  function automatic pidf_pkg::pidf_in_t mk_item(input logic op,
                                                 input logic [pidf_pkg::CHAN_W-1:0] ch,
                                                 input logic signed [pidf_pkg::VAL_W-1:0] v);
    pidf_pkg::pidf_in_t item;
    item.operation = op;
    item.channel   = ch;
    item.value     = v;
    return item;
  endfunction

  // wait cycles before a transfer, zero when that side runs flat out
  function automatic int unsigned draw_wait(input bit on);
    if (!on || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // speeds: extremes, zero, near the channel's target, or anything
  function automatic logic signed [pidf_pkg::VAL_W-1:0] rand_speed(input int unsigned ch);
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3, 4, 5: return spd_target[ch] + {{(pidf_pkg::VAL_W-13){r[12]}}, r[12:0]};
      default: return r[pidf_pkg::VAL_W-1:0];
    endcase
  endfunction

  function automatic logic [pidf_pkg::CFG_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return GAIN_MAX;
      5: return pidf_pkg::CFG_W'($urandom());
      default: return pidf_pkg::CFG_W'($urandom_range(0, 2 * GAIN_ONE));
    endcase
  endfunction

  // smoothing weights, upper write bits sometimes set
  function automatic logic [pidf_pkg::CFG_W-1:0] rand_smoothing();
    logic [pidf_pkg::BETA_W-1:0] b;
    case ($urandom_range(0, 4))
      0: b = '0;
      1: b = pidf_pkg::BETA_ONE;
      2: b = pidf_pkg::BETA_RESET;
      3: b = pidf_pkg::BETA_W'($urandom_range(pidf_pkg::BETA_ONE + 1,
                                              (1 << pidf_pkg::BETA_W) - 1));
      default: b = pidf_pkg::BETA_W'($urandom_range(0, pidf_pkg::BETA_ONE));
    endcase
    return {(pidf_pkg::CFG_W-pidf_pkg::BETA_W)'($urandom()), b};
  endfunction

  // one input transfer, predicted at the edge that takes it
  task automatic send_item(input pidf_pkg::pidf_in_t item);
    int unsigned         gap;
    pidf_pkg::pidf_out_t res;
    gap = draw_wait(in_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (pid_step(item, res)) begin
      drive_expect_q.push_back(res);
    end
    if (item.channel >= CHANNELS) begin
      dropped_sent++;
    end else if (item.operation == pidf_pkg::OP_SETPOINT) begin
      setpoints_sent++;
    end else begin
      samples_sent++;
    end
  endtask

  // let every pending drive value arrive and the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pidf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pidf_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pidf_pkg::CFG_GAIN_P: kp = data[pidf_pkg::GAIN_W-1:0];
      pidf_pkg::CFG_GAIN_I: ki = data[pidf_pkg::GAIN_W-1:0];
      pidf_pkg::CFG_GAIN_D: kd = data[pidf_pkg::GAIN_W-1:0];
      pidf_pkg::CFG_SMOOTH: beta_reg = data[pidf_pkg::BETA_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic write_gains(input logic [pidf_pkg::CFG_W-1:0] p,
                             input logic [pidf_pkg::CFG_W-1:0] i,
                             input logic [pidf_pkg::CFG_W-1:0] d,
                             input logic [pidf_pkg::CFG_W-1:0] s);
    settle();
    write_reg(pidf_pkg::CFG_GAIN_P, p);
    write_reg(pidf_pkg::CFG_GAIN_I, i);
    write_reg(pidf_pkg::CFG_GAIN_D, d);
    write_reg(pidf_pkg::CFG_SMOOTH, s);
  endtask

  // reset gains are zero, so drive equals feedback
  task automatic test_reset_defaults();
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd0, 24'sh123456));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd1, VAL_MAX));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd2, VAL_MIN));
  endtask

  // full-scale gains and errors, drive saturating both ways
  task automatic test_extremes();
    write_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, '0);
    send_item(mk_item(pidf_pkg::OP_SETPOINT, 2'd0, VAL_MAX));
    send_item(mk_item(pidf_pkg::OP_SETPOINT, 2'd1, VAL_MIN));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd0, VAL_MIN));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd1, VAL_MAX));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd0, VAL_MIN));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd0, VAL_MAX));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd2, '0));
  endtask

  // items on a channel past the last one are dropped
  task automatic test_dropped_channel();
    send_item(mk_item(pidf_pkg::OP_SETPOINT, 2'd3, VAL_MAX));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd3, VAL_MIN));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd2, 24'sh000100));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd3, 24'($urandom())));
  endtask

  // filter weight at one, above one (treated as one) and at zero
  task automatic test_smoothing_limits();
    write_gains(GAIN_ONE, '0, GAIN_ONE, pidf_pkg::BETA_ONE);
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd2, 24'sh001000));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd2, -24'sh002000));
    settle();
    write_reg(pidf_pkg::CFG_SMOOTH, {pidf_pkg::CFG_W{1'b1}});
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd2, 24'sh004000));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd2, 24'sh000000));
    settle();
    write_reg(pidf_pkg::CFG_SMOOTH, '0);
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd2, 24'sh7F0000));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd2, -24'sh7F0000));
  endtask

  // full error on one channel, integral building up over back-to-back samples
  task automatic test_integral_windup();
    write_gains('0, 24'h000100, '0, pidf_pkg::BETA_RESET);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    send_item(mk_item(pidf_pkg::OP_SETPOINT, 2'd1, VAL_MAX));
    repeat (WINDUP_ITEMS) send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd1, VAL_MIN));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd1, VAL_MAX));
    send_item(mk_item(pidf_pkg::OP_SETPOINT, 2'd1, '0));
    send_item(mk_item(pidf_pkg::OP_SAMPLE, 2'd1, VAL_MIN));
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // random phases, each under its own gains and smoothing
  task automatic test_random_phases();
    int unsigned counted;
    int unsigned r;
    int unsigned ch;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      write_gains(rand_gain(), rand_gain(), rand_gain(), rand_smoothing());
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(0, 39) == 0) in_idle_on = !in_idle_on;
        if ($urandom_range(0, 39) == 0) out_idle_on = !out_idle_on;
        r = $urandom_range(0, 99);
        if (r < 5) begin
          send_item(mk_item(1'($urandom()), 2'd3, 24'($urandom())));
        end else begin
          ch = $urandom_range(0, CHANNELS - 1);
          if (r < 15) begin
            send_item(mk_item(pidf_pkg::OP_SETPOINT, ch[pidf_pkg::CHAN_W-1:0],
                              rand_speed(ch)));
          end else begin
            send_item(mk_item(pidf_pkg::OP_SAMPLE, ch[pidf_pkg::CHAN_W-1:0],
                              rand_speed(ch)));
          end
          counted++;
        end
      end
    end
  endtask

  // check each drive transfer and stall the receiver for a random spell after it
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (drive_expect_q.size() == 0) begin
        $error("drive transfer with nothing pending: out_channel %0d drive %0d",
               out_data.out_channel, out_data.drive);
        mismatches++;
      end else begin
        want = drive_expect_q.pop_front();
        if (out_data.out_channel !== want.out_channel) begin
          $error("out_channel: expected %0d, got %0d", want.out_channel, out_data.out_channel);
          mismatches++;
        end
        if (out_data.drive !== want.drive) begin
          $error("drive: expected %0d, got %0d", want.drive, out_data.drive);
          mismatches++;
        end
        drives_seen++;
      end
      out_hold = draw_wait(out_idle_on);
    end
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // run watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped after %0d cycles, %0d drive values outstanding",
             cycle_count, drive_expect_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    kp       = '0;
    ki       = '0;
    kd       = '0;
    beta_reg = pidf_pkg::BETA_RESET;
    for (int c = 0; c < CHANNELS; c++) begin
      spd_target[c]   = '0;
      spd_last_err[c] = '0;
      spd_err_sum[c]  = '0;
      spd_slope[c]    = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_extremes();
    test_dropped_channel();
    test_smoothing_limits();
    test_integral_windup();
    test_random_phases();
    settle();
    $display("sent %0d samples, %0d setpoints and %0d dropped-channel items over %0d reg writes",
             samples_sent, setpoints_sent, dropped_sent, cfg_writes);
    $display("checked %0d drive values including integral buildup, %0d mismatches",
             drives_seen, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
